@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, prop)
`define ASSERT_NEVER(name, expr)
`endif

`endif

@@ sv/smp_pkg.sv @@
// ----------------------------------------------------------------------------
// smp_pkg
// Types and codes shared by the serial memory programmer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smp_pkg;

  // Frame parser phases, one-hot
  typedef enum logic [8:0] {
    PH_CMD        = 9'b000000001,
    PH_LEN_LO     = 9'b000000010,
    PH_LEN_HI     = 9'b000000100,
    PH_ADR_LO     = 9'b000001000,
    PH_ADR_HI     = 9'b000010000,
    PH_CNT_LO     = 9'b000100000,
    PH_CNT_HI     = 9'b001000000,
    PH_READ_WAIT  = 9'b010000000,
    PH_WRITE_DATA = 9'b100000000
  } phase_e;

  // Input word source
  localparam logic ITEM_SERIAL = 1'b0;
  localparam logic ITEM_MEM    = 1'b1;

  // Result word kinds
  localparam logic [1:0] RES_SERIAL = 2'd0;
  localparam logic [1:0] RES_READ   = 2'd1;
  localparam logic [1:0] RES_WRITE  = 2'd2;

  // Command codes
  localparam logic [7:0] CMD_READY = 8'h01;
  localparam logic [7:0] CMD_READ  = 8'h02;
  localparam logic [7:0] CMD_WRITE = 8'h03;

  // Reply bytes
  localparam logic [7:0] BYTE_ACK = 8'hFF;
  localparam logic [7:0] BYTE_NAK = 8'hEE;

  typedef struct packed {
    logic [1:0]  kind_res;
    logic [15:0] address;
    logic [7:0]  value_res;
    logic        page_mode;
    logic        chunk_end;
    logic        last;
  } result_t;

endpackage

@@ sv/smp_if.sv @@
// ----------------------------------------------------------------------------
// smp_in_if / smp_out_if
// Valid/ready channels of the parser: input words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface smp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind_res;
  logic [15:0] address;
  logic [7:0]  value_res;
  logic        page_mode;
  logic        chunk_end;
  logic        last;

  modport source (output valid, output kind_res, output address, output value_res,
                  output page_mode, output chunk_end, output last, input ready);
  modport sink   (input valid, input kind_res, input address, input value_res,
                  input page_mode, input chunk_end, input last, output ready);
endinterface

@@ sv/smp_parser.sv @@
// ----------------------------------------------------------------------------
// smp_parser
// Frame parser and command sequencer; emits up to two result words per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smp_parser #(
  parameter int PAGE_BYTES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             kind_i,
  input  logic [7:0]       value_i,
  output smp_pkg::result_t res0_o,
  output smp_pkg::result_t res1_o,
  output logic [1:0]       n_res_o
);
  import smp_pkg::*;

  localparam int PosW  = $clog2(PAGE_BYTES);
  localparam int PageW = $clog2(PAGE_BYTES + 1);
  // ceil(2^32 / PAGE_BYTES): exact quotient for any 16-bit dividend
  localparam logic [31:0] RecipM = 32'(((64'd1 << 32) + PAGE_BYTES - 1) / PAGE_BYTES);

  phase_e            phase_q, phase_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [15:0]       start_q, start_d;
  logic [15:0]       count_q, count_d;
  logic [15:0]       done_q, done_d;
  logic              in_page_q, in_page_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       quot_q, quot_d;
  logic [PosW-1:0]   smod_q;

  logic [15:0]       adr_full;
  logic [47:0]       prod;
  logic [15:0]       qp;
  logic [15:0]       cnt_full;
  logic [15:0]       nd;
  logic              fin;
  logic              wrap_pos;

  // Chunk starting at done lies in one page: no wrap past 0xFFFF and
  // (start mod P) + n <= P. Chunk starts are multiples of P from start.
  function automatic logic plan_chunk(input logic [15:0] start, input logic [15:0] bc,
                                      input logic [15:0] done, input logic [PosW-1:0] smod);
    logic [15:0]      left;
    logic [PageW-1:0] n;
    logic [16:0]      first;
    logic [17:0]      end_x;
    logic [9:0]       span;
    left  = bc - done;
    n     = (left < 16'(PAGE_BYTES)) ? left[PageW-1:0] : PageW'(PAGE_BYTES);
    first = {1'b0, start} + {1'b0, done};
    end_x = {1'b0, first} + 18'(n);
    span  = 10'(smod) + 10'(n);
    return (end_x <= 18'h10000) && (span <= 10'(PAGE_BYTES));
  endfunction

  assign adr_full = {value_i, start_q[7:0]};
  assign prod     = 48'(adr_full) * 48'(RecipM);
  assign qp       = 16'(quot_q * 16'(PAGE_BYTES));
  assign cnt_full = {value_i, count_q[7:0]};
  assign nd       = done_q + 16'd1;
  assign fin      = (nd == count_q);
  assign wrap_pos = (pos_q == PosW'(PAGE_BYTES - 1));

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    start_d   = start_q;
    count_d   = count_q;
    done_d    = done_q;
    in_page_d = in_page_q;
    pos_d     = pos_q;
    quot_d    = quot_q;
    res0_o    = '0;
    res1_o    = '0;
    n_res_o   = 2'd0;

    if (accept_i) begin
      if (phase_q == PH_READ_WAIT) begin
        if (kind_i == ITEM_MEM) begin
          done_d           = nd;
          n_res_o          = 2'd2;
          res0_o.kind_res  = RES_SERIAL;
          res0_o.value_res = value_i;
          res1_o.last      = 1'b1;
          if (fin) begin
            phase_d          = PH_CMD;
            res1_o.kind_res  = RES_SERIAL;
            res1_o.value_res = BYTE_ACK;
          end else begin
            res1_o.kind_res = RES_READ;
            res1_o.address  = start_q + nd;
          end
        end
      end else if (kind_i == ITEM_SERIAL) begin
        case (phase_q)
          PH_CMD: begin
            cmd_d   = value_i;
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            phase_d = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (cmd_q == CMD_READ || cmd_q == CMD_WRITE) begin
              phase_d = PH_ADR_LO;
            end else begin
              phase_d          = PH_CMD;
              n_res_o          = 2'd1;
              res0_o.kind_res  = RES_SERIAL;
              res0_o.value_res = (cmd_q == CMD_READY) ? BYTE_ACK : BYTE_NAK;
              res0_o.last      = 1'b1;
            end
          end
          PH_ADR_LO: begin
            start_d = {8'd0, value_i};
            phase_d = PH_ADR_HI;
          end
          PH_ADR_HI: begin
            start_d = adr_full;
            quot_d  = prod[47:32];
            phase_d = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            count_d = {8'd0, value_i};
            phase_d = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            count_d = cnt_full;
            done_d  = 16'd0;
            pos_d   = '0;
            if (cnt_full == 16'd0) begin
              phase_d          = PH_CMD;
              n_res_o          = 2'd1;
              res0_o.kind_res  = RES_SERIAL;
              res0_o.value_res = BYTE_ACK;
              res0_o.last      = 1'b1;
            end else if (cmd_q == CMD_READ) begin
              phase_d         = PH_READ_WAIT;
              n_res_o         = 2'd1;
              res0_o.kind_res = RES_READ;
              res0_o.address  = start_q;
              res0_o.last     = 1'b1;
            end else begin
              phase_d   = PH_WRITE_DATA;
              in_page_d = plan_chunk(start_q, cnt_full, 16'd0, smod_q);
            end
          end
          PH_WRITE_DATA: begin
            done_d           = nd;
            pos_d            = wrap_pos ? '0 : pos_q + PosW'(1);
            res0_o.kind_res  = RES_WRITE;
            res0_o.address   = start_q + done_q;
            res0_o.value_res = value_i;
            res0_o.page_mode = in_page_q;
            res0_o.chunk_end = fin || wrap_pos;
            if (fin) begin
              phase_d          = PH_CMD;
              n_res_o          = 2'd2;
              res1_o.kind_res  = RES_SERIAL;
              res1_o.value_res = BYTE_ACK;
              res1_o.last      = 1'b1;
            end else begin
              n_res_o     = 2'd1;
              res0_o.last = 1'b1;
              if (wrap_pos) begin
                in_page_d = plan_chunk(start_q, count_q, nd, smod_q);
              end
            end
          end
          default: begin
            phase_d = PH_CMD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      cmd_q     <= '0;
      start_q   <= '0;
      count_q   <= '0;
      done_q    <= '0;
      in_page_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      start_q   <= start_d;
      count_q   <= count_d;
      done_q    <= done_d;
      in_page_q <= in_page_d;
      pos_q     <= pos_d;
    end
  end

  // start mod P, registered from the registered quotient
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    smod_q <= PosW'(start_q - qp);
  end

  `ASSERT_CLK(a_done_below_count,
    (phase_q == PH_READ_WAIT || phase_q == PH_WRITE_DATA) |-> done_q < count_q)
  `ASSERT_CLK(a_pair_last_on_second, n_res_o == 2'd2 |-> res1_o.last && !res0_o.last)
  `ASSERT_CLK(a_short_cmd_returns,
    (accept_i && phase_q == PH_LEN_HI && kind_i == ITEM_SERIAL && cmd_q != CMD_READ
     && cmd_q != CMD_WRITE) |=> phase_q == PH_CMD)

endmodule

@@ sv/smp_out_queue.sv @@
// ----------------------------------------------------------------------------
// smp_out_queue
// Four-word result buffer; takes up to two words per cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smp_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  smp_pkg::result_t data0_i,
  input  smp_pkg::result_t data1_i,
  output logic             space_o,
  output logic             valid_o,
  output smp_pkg::result_t data_o,
  input  logic             pop_i
);
  import smp_pkg::*;

  localparam int Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic [1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + 2'd1;
  assign space_o   = (count_q <= 3'(Depth - 2));
  assign valid_o   = (count_q != 3'd0);
  assign data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n_i;
      rd_ptr_q <= rd_ptr_q + 2'(pop_i);
      count_q  <= count_q + 3'(push_n_i) - 3'(pop_i);
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= 3'(Depth))
  `ASSERT_CLK(a_pair_fits, push_n_i == 2'd2 |-> count_q <= 3'(Depth - 2))
  `ASSERT_NEVER(a_pop_empty, pop_i && count_q == 3'd0)

endmodule

@@ sv/serial_memory_programmer_parser.sv @@
// ----------------------------------------------------------------------------
// serial_memory_programmer_parser
// Parses programmer frames from serial bytes and memory read data, and
// produces serial replies, memory read requests and paged memory writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Channel | Dir | Word
// --------+-----+-----------------------------------------------------------
// in_i    | in  | kind (serial byte / memory data), value
// out_o   | out | kind_res, address, value_res, page_mode, chunk_end, last
//
// Each input word is handled in the cycle it is accepted; its results land in
// a four-word output buffer and leave one per cycle while the output is ready.
// Input ready is high while the buffer has room for two words, so one word per
// cycle goes through while each gives at most one result and the output is
// ready; a word giving two results (read data, final write) sends them in turn.
// Reset (async, active low) returns the parser to waiting for a command byte
// and empties the buffer. A stalled output keeps its word until taken.

module serial_memory_programmer_parser #(
  parameter int PAGE_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smp_in_if.sink    in_i,
  smp_out_if.source out_o
);
  import smp_pkg::*;

  logic       accept;
  logic       pop;
  logic       space;
  logic [1:0] n_res;
  result_t    res0;
  result_t    res1;
  result_t    head;

  // Input handshake: gate only on buffer room, never on parser phase
  assign in_i.ready = space;
  assign accept     = in_i.valid && space;
  assign pop        = out_o.valid && out_o.ready;

  // Frame parser: phase, address, count and chunk bookkeeping
  smp_parser #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .kind_i  (in_i.kind),
    .value_i (in_i.value),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_res_o (n_res)
  );

  // Result buffer decouples the two sides
  smp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(n_res),
    .data0_i (res0),
    .data1_i (res1),
    .space_o (space),
    .valid_o (out_o.valid),
    .data_o  (head),
    .pop_i   (pop)
  );

  assign out_o.kind_res  = head.kind_res;
  assign out_o.address   = head.address;
  assign out_o.value_res = head.value_res;
  assign out_o.page_mode = head.page_mode;
  assign out_o.chunk_end = head.chunk_end;
  assign out_o.last      = head.last;

endmodule
